FILE: src/chained_hash_table_engine_macros.svh
// Assertion macros for the chained hash table engine.
// Used by chained_hash_table_engine.sv; no other dependencies.
`ifndef CHAINED_HASH_TABLE_ENGINE_MACROS_SVH
`define CHAINED_HASH_TABLE_ENGINE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define CHT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define CHT_ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`else

`define CHT_ASSERT(name, prop, msg)

`define CHT_ASSERT_IMPLY(name, ante, cons, msg)

`endif

`endif

FILE: src/cht_pkg.sv
// Shared constants, types and helper functions of the chained hash table engine.
// No dependencies; imported by cht_store and chained_hash_table_engine.
`default_nettype none

package cht_pkg;

  localparam int MAX_BUCKETS      = 256;
  localparam int SLOTS_PER_BUCKET = 4;
  localparam int KEY_BYTES        = 8;

  localparam int TOTAL_SLOTS = MAX_BUCKETS * SLOTS_PER_BUCKET;
  localparam int KEY_W       = 8 * KEY_BYTES;
  localparam int KEY_PORT_W  = 64;
  localparam int VAL_W       = 32;
  localparam int SIZE_W      = 16;
  localparam int REQ_W       = 2;
  localparam int CFG_W       = 9;

  localparam int BC_W    = $clog2(MAX_BUCKETS + 1);
  localparam int BKT_W   = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int SIDX_W  = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int SADDR_W = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
  localparam int KIDX_W  = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam int SUM_W   = $clog2(KEY_BYTES * 255 + 1);
  localparam int ADD_W   = (SUM_W > BC_W + 1) ? SUM_W : BC_W + 1;

  localparam int STEP_MAX0 = (KEY_BYTES > SUM_W) ? KEY_BYTES : SUM_W;
  localparam int STEP_MAX  = (STEP_MAX0 > SLOTS_PER_BUCKET) ? STEP_MAX0 : SLOTS_PER_BUCKET;
  localparam int STEP_W    = $clog2(STEP_MAX + 1);

  localparam int RESET_BC = (MAX_BUCKETS < 256) ? MAX_BUCKETS : 256;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_GET    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PUT    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

  // Access to the slot store; one row of valid bits per bucket.
  typedef struct packed {
    logic                        row_rd;
    logic                        row_wr;
    logic [BKT_W-1:0]            row_addr;
    logic [SLOTS_PER_BUCKET-1:0] row_wdata;
    logic                        slot_rd;
    logic                        slot_wr;
    logic                        key_wr;
    logic [SADDR_W-1:0]          slot_addr;
    logic [KEY_W-1:0]            key;
    logic [VAL_W-1:0]            value;
    logic [SIZE_W-1:0]           size;
  } mem_req_t;

  // A written bucket count of zero is taken as one; large values saturate.
  function automatic logic [BC_W-1:0] sat_bucket_count(input logic [CFG_W-1:0] v);
    logic [BC_W-1:0] r;
    if (v == '0) begin
      r = BC_W'(1);
    end else if (int'(v) > MAX_BUCKETS) begin
      r = BC_W'(MAX_BUCKETS);
    end else begin
      r = BC_W'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: src/chained_hash_table_engine.sv
// Chained hash table engine: a request runs through the byte sum (S_SUM), the remainder
// (S_MOD), the row read (S_ROW), the slot scan (S_SCAN) and S_ACT to its result strobe;
// busy is low again in the strobe cycle, so the next request is taken at the earliest at
// the edge ending that cycle; a new request is not taken before the last one is through.
// It uses one shared adder (byte sum, then one remainder bit per cycle) and one slot read per cycle.
// Reset and every bucket count write clear all valid rows in one pass with busy high.
// The result is shown for one cycle only; the receiver cannot stall it.
`default_nettype none

`include "chained_hash_table_engine_macros.svh"

module chained_hash_table_engine (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [cht_pkg::REQ_W-1:0]      req_type_i,
  input  logic [cht_pkg::KEY_PORT_W-1:0] key_i,
  input  logic [cht_pkg::VAL_W-1:0]      new_value_i,
  input  logic [cht_pkg::SIZE_W-1:0]     new_size_i,
  input  logic                           cfg_we_i,
  input  logic [cht_pkg::CFG_W-1:0]      cfg_wdata_i,
  output logic                           result_valid_o,
  output logic                           ok_o,
  output logic                           found_o,
  output logic [cht_pkg::VAL_W-1:0]      value_out_o,
  output logic [cht_pkg::SIZE_W-1:0]     size_out_o
);
  import cht_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SUM, S_MOD, S_ROW, S_SCAN, S_ACT
  } state_e;

  state_e state_q, state_d;
  logic [STEP_W-1:0]              step_q, step_d;
  logic [BKT_W-1:0]               clr_q, clr_d;
  logic [BC_W-1:0]                bc_q, bc_d;
  logic [REQ_W-1:0]               req_q, req_d;
  logic [KEY_BYTES-1:0][7:0]      key_q, key_d;
  logic [VAL_W-1:0]               nval_q, nval_d;
  logic [SIZE_W-1:0]              nsz_q, nsz_d;
  logic [SUM_W-1:0]               acc_q, acc_d;
  logic [BC_W-1:0]                rem_q, rem_d;
  logic [SADDR_W-1:0]             base_q, base_d;
  logic                           have_hit_q, have_hit_d;
  logic                           have_free_q, have_free_d;
  logic [SIDX_W-1:0]              hit_q, hit_d;
  logic [SIDX_W-1:0]              free_q, free_d;
  logic [VAL_W-1:0]               vout_q, vout_d;
  logic [SIZE_W-1:0]              sout_q, sout_d;
  logic                           res_valid_q, res_valid_d;
  logic                           ok_q, ok_d;
  logic                           found_q, found_d;
  logic [VAL_W-1:0]               value_q, value_d;
  logic [SIZE_W-1:0]              size_q, size_d;

  // The one shared adder: byte accumulation, then restoring remainder trials.
  logic [ADD_W-1:0] add_a, add_b;
  logic             add_cin;
  logic [ADD_W:0]   add_res;
  logic [BC_W:0]    rem_shift;

  mem_req_t                    mreq;
  logic [SLOTS_PER_BUCKET-1:0] row_rdata;
  logic [KEY_W-1:0]            key_rdata;
  logic [VAL_W-1:0]            value_rdata;
  logic [SIZE_W-1:0]           size_rdata;

  logic [STEP_W-1:0] step_prev;
  logic [SIDX_W-1:0] cmp_idx;
  logic              cmp_valid;
  logic              hit_act;

  cht_store u_store (
    .clk_i         (clk_i),
    .req_i         (mreq),
    .row_rdata_o   (row_rdata),
    .key_rdata_o   (key_rdata),
    .value_rdata_o (value_rdata),
    .size_rdata_o  (size_rdata)
  );

  assign rem_shift = {rem_q, acc_q[SUM_W-1]};
  assign add_res   = {1'b0, add_a} + {1'b0, add_b} + (ADD_W + 1)'(add_cin);
  assign step_prev = step_q - STEP_W'(1);
  assign cmp_idx   = step_prev[SIDX_W-1:0];
  assign cmp_valid = row_rdata[cmp_idx];
  assign hit_act   = have_hit_q && (req_q == REQ_GET || req_q == REQ_PUT ||
                                    req_q == REQ_REMOVE);

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    clr_d       = clr_q;
    bc_d        = bc_q;
    req_d       = req_q;
    key_d       = key_q;
    nval_d      = nval_q;
    nsz_d       = nsz_q;
    acc_d       = acc_q;
    rem_d       = rem_q;
    base_d      = base_q;
    have_hit_d  = have_hit_q;
    have_free_d = have_free_q;
    hit_d       = hit_q;
    free_d      = free_q;
    vout_d      = vout_q;
    sout_d      = sout_q;
    res_valid_d = 1'b0;
    ok_d        = ok_q;
    found_d     = found_q;
    value_d     = value_q;
    size_d      = size_q;
    add_a       = '0;
    add_b       = '0;
    add_cin     = 1'b0;
    mreq        = '0;
    mreq.key    = KEY_W'(key_q);
    mreq.value  = nval_q;
    mreq.size   = nsz_q;

    case (state_q)
      S_CLEAR: begin
        mreq.row_wr   = 1'b1;
        mreq.row_addr = clr_q;
        clr_d         = clr_q + BKT_W'(1);
        if (clr_q == BKT_W'(MAX_BUCKETS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          req_d   = req_type_i;
          key_d   = key_i[KEY_W-1:0];
          nval_d  = new_value_i;
          nsz_d   = new_size_i;
          acc_d   = '0;
          rem_d   = '0;
          step_d  = '0;
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        add_a  = ADD_W'(acc_q);
        add_b  = ADD_W'(key_q[step_q[KIDX_W-1:0]]);
        acc_d  = add_res[SUM_W-1:0];
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(KEY_BYTES - 1)) begin
          step_d  = '0;
          state_d = S_MOD;
        end
      end
      S_MOD: begin
        // Subtract the bucket count from the shifted remainder; keep it if no borrow.
        add_a   = ADD_W'(rem_shift);
        add_b   = ~ADD_W'(bc_q);
        add_cin = 1'b1;
        rem_d   = add_res[ADD_W] ? add_res[BC_W-1:0] : rem_shift[BC_W-1:0];
        acc_d   = acc_q << 1;
        step_d  = step_q + STEP_W'(1);
        if (step_q == STEP_W'(SUM_W - 1)) begin
          step_d  = '0;
          state_d = S_ROW;
        end
      end
      S_ROW: begin
        mreq.row_rd   = 1'b1;
        mreq.row_addr = rem_q[BKT_W-1:0];
        base_d        = SADDR_W'(int'(rem_q[BKT_W-1:0]) * SLOTS_PER_BUCKET);
        have_hit_d    = 1'b0;
        have_free_d   = 1'b0;
        hit_d         = '0;
        free_d        = '0;
        vout_d        = '0;
        sout_d        = '0;
        state_d       = S_SCAN;
      end
      S_SCAN: begin
        // Read slot step_q while judging slot step_q - 1, whose data is now back.
        if (step_q < STEP_W'(SLOTS_PER_BUCKET)) begin
          mreq.slot_rd   = 1'b1;
          mreq.slot_addr = base_q + SADDR_W'(step_q);
        end
        if (step_q != '0) begin
          if (cmp_valid) begin
            if (!have_hit_q && key_rdata == KEY_W'(key_q)) begin
              have_hit_d = 1'b1;
              hit_d      = cmp_idx;
              vout_d     = value_rdata;
              sout_d     = size_rdata;
            end
          end else if (!have_free_q) begin
            have_free_d = 1'b1;
            free_d      = cmp_idx;
          end
        end
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(SLOTS_PER_BUCKET)) begin
          step_d  = '0;
          state_d = S_ACT;
        end
      end
      S_ACT: begin
        res_valid_d   = 1'b1;
        ok_d          = 1'b0;
        found_d       = 1'b0;
        value_d       = '0;
        size_d        = '0;
        mreq.row_addr = rem_q[BKT_W-1:0];
        if (hit_act) begin
          ok_d           = 1'b1;
          found_d        = 1'b1;
          value_d        = vout_q;
          size_d         = sout_q;
          mreq.slot_addr = base_q + SADDR_W'(hit_q);
          if (req_q == REQ_PUT) begin
            mreq.slot_wr = 1'b1;
          end else if (req_q == REQ_REMOVE) begin
            mreq.row_wr    = 1'b1;
            mreq.row_wdata = row_rdata & ~(SLOTS_PER_BUCKET'(1) << hit_q);
          end
        end else if (req_q == REQ_PUT && have_free_q) begin
          ok_d           = 1'b1;
          mreq.slot_addr = base_q + SADDR_W'(free_q);
          mreq.slot_wr   = 1'b1;
          mreq.key_wr    = 1'b1;
          mreq.row_wr    = 1'b1;
          mreq.row_wdata = row_rdata | (SLOTS_PER_BUCKET'(1) << free_q);
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // A bucket count write restarts the clearing pass.
    if (cfg_we_i) begin
      bc_d    = sat_bucket_count(cfg_wdata_i);
      clr_d   = '0;
      state_d = S_CLEAR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      step_q      <= '0;
      clr_q       <= '0;
      bc_q        <= BC_W'(RESET_BC);
      req_q       <= '0;
      key_q       <= '0;
      nval_q      <= '0;
      nsz_q       <= '0;
      acc_q       <= '0;
      rem_q       <= '0;
      base_q      <= '0;
      have_hit_q  <= 1'b0;
      have_free_q <= 1'b0;
      hit_q       <= '0;
      free_q      <= '0;
      vout_q      <= '0;
      sout_q      <= '0;
      res_valid_q <= 1'b0;
      ok_q        <= 1'b0;
      found_q     <= 1'b0;
      value_q     <= '0;
      size_q      <= '0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      clr_q       <= clr_d;
      bc_q        <= bc_d;
      req_q       <= req_d;
      key_q       <= key_d;
      nval_q      <= nval_d;
      nsz_q       <= nsz_d;
      acc_q       <= acc_d;
      rem_q       <= rem_d;
      base_q      <= base_d;
      have_hit_q  <= have_hit_d;
      have_free_q <= have_free_d;
      hit_q       <= hit_d;
      free_q      <= free_d;
      vout_q      <= vout_d;
      sout_q      <= sout_d;
      res_valid_q <= res_valid_d;
      ok_q        <= ok_d;
      found_q     <= found_d;
      value_q     <= value_d;
      size_q      <= size_d;
    end
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = res_valid_q;
  assign ok_o           = ok_q;
  assign found_o        = found_q;
  assign value_out_o    = value_q;
  assign size_out_o     = size_q;

  `CHT_ASSERT(a_strobe_single, res_valid_q |=> !res_valid_q, "result strobe longer than one cycle")
  `CHT_ASSERT_IMPLY(a_found_ok, res_valid_q && found_q, ok_q, "found result without ok")
  `CHT_ASSERT_IMPLY(a_miss_zero, res_valid_q && !found_q, value_q == '0 && size_q == '0, "absent key returned nonzero data")
  `CHT_ASSERT_IMPLY(a_bucket_range, state_q == S_ROW, rem_q < bc_q, "bucket index not below bucket count")
  `CHT_ASSERT(a_accept_busy, start && !busy && !cfg_we_i |=> busy, "accepted request did not raise busy")

endmodule

`default_nettype wire

FILE: src/cht_store.sv
// Slot store: key, value and size memories plus one row of valid bits per bucket.
// Depends on cht_pkg; all reads are registered.
`default_nettype none

module cht_store (
  input  logic                                  clk_i,
  input  cht_pkg::mem_req_t                     req_i,
  output logic [cht_pkg::SLOTS_PER_BUCKET-1:0]  row_rdata_o,
  output logic [cht_pkg::KEY_W-1:0]             key_rdata_o,
  output logic [cht_pkg::VAL_W-1:0]             value_rdata_o,
  output logic [cht_pkg::SIZE_W-1:0]            size_rdata_o
);
  import cht_pkg::*;

  logic [SLOTS_PER_BUCKET-1:0] row_mem   [MAX_BUCKETS];
  logic [KEY_W-1:0]            key_mem   [TOTAL_SLOTS];
  logic [VAL_W-1:0]            value_mem [TOTAL_SLOTS];
  logic [SIZE_W-1:0]           size_mem  [TOTAL_SLOTS];

  logic [SLOTS_PER_BUCKET-1:0] row_rdata_q;
  logic [KEY_W-1:0]            key_rdata_q;
  logic [VAL_W-1:0]            value_rdata_q;
  logic [SIZE_W-1:0]           size_rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.row_wr) begin
      row_mem[req_i.row_addr] <= req_i.row_wdata;
    end
    if (req_i.row_rd) begin
      row_rdata_q <= row_mem[req_i.row_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.key_wr) begin
      key_mem[req_i.slot_addr] <= req_i.key;
    end
    if (req_i.slot_wr) begin
      value_mem[req_i.slot_addr] <= req_i.value;
      size_mem[req_i.slot_addr]  <= req_i.size;
    end
    if (req_i.slot_rd) begin
      key_rdata_q   <= key_mem[req_i.slot_addr];
      value_rdata_q <= value_mem[req_i.slot_addr];
      size_rdata_q  <= size_mem[req_i.slot_addr];
    end
  end

  assign row_rdata_o   = row_rdata_q;
  assign key_rdata_o   = key_rdata_q;
  assign value_rdata_o = value_rdata_q;
  assign size_rdata_o  = size_rdata_q;

endmodule

`default_nettype wire
